>>> rtl/http_request_framer_unit_assert.svh
// ----------------------------------------------------------------------------
// HTTP request framer assertion macros
// Shared property forms for the framer's checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

>>> rtl/hrf_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request framer package
// Types, codes and lookup functions shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

    localparam int METHOD_BYTES = 8;
    localparam int PATH_BYTES   = 64;
    localparam logic [4:0] CL_NAME_LEN = 5'd14;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_PATH   = 3'd1,
        PH_REST   = 3'd2,
        PH_HEADER = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        LP_NAME   = 3'd0,
        LP_LEAD   = 3'd1,
        LP_DIGITS = 3'd2,
        LP_TRAIL  = 3'd3,
        LP_SKIP   = 3'd4,
        LP_DONE   = 3'd5
    } lp_t;

    localparam logic [1:0] ST_BUSY      = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [7:0] REG_HEADER_LIMIT = 8'd0;
    localparam logic [7:0] REG_BODY_LIMIT   = 8'd1;

    // Content-Length parser state carried between bytes.
    typedef struct packed {
        lp_t         lp;
        logic [4:0]  name_pos;
        logic [31:0] accum;
        logic        present;
        logic        invalid;
        logic        overflow;
    } len_state_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    // Lower-case text of "content-length".
    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "l";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Candidate 0 is post, 1 is put, 2 is patch.
    function automatic logic [4:0] meth_len(input logic [1:0] i);
        logic [4:0] n;
        case (i)
            2'd0:    n = 5'd4;
            2'd1:    n = 5'd3;
            default: n = 5'd5;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] meth_char(input logic [1:0] i, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (i)
            2'd0:
            begin
                case (pos)
                    3'd0:    c = "p";
                    3'd1:    c = "o";
                    3'd2:    c = "s";
                    3'd3:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    3'd0:    c = "p";
                    3'd1:    c = "u";
                    3'd2:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    c = "p";
                    3'd1:    c = "a";
                    3'd2:    c = "t";
                    3'd3:    c = "c";
                    3'd4:    c = "h";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/http_request_framer_unit.sv
// ----------------------------------------------------------------------------
// HTTP request framer
// Byte-serial HTTP/1.1 request splitter with header checks and body counting.
// ----------------------------------------------------------------------------
// Each byte of the request stream is tagged with the part of the request it
// belongs to and comes out in the cycle after it is accepted; a new byte can be
// taken every cycle, since the whole per-byte update is one pass of logic
// between the parser state registers and the output register. The output
// register holds a result while the downstream side stalls, and in_stall
// rises only when that register is full and stalled. The header ends at
// CR LF CR LF or LF LF; on that byte the request line, the first
// Content-Length line and the declared length are judged, and either the
// request ends there or the declared number of body bytes follows. After
// any byte flagged request_last the parser returns to its reset state.
// header_limit (index 0) and body_limit (index 1) are written through the
// configuration port, which is always ready; other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_framer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request byte stream.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    // Tagged result stream.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [2:0]       byte_region,
    output logic             request_last,
    output logic [1:0]       status,
    output logic [15:0]      declared_length,
    output logic             body_required,
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [4:0] METHOD_MAX = 5'(hrf_pkg::METHOD_BYTES - 1);
    localparam logic [7:0] PATH_MAX   = 8'(hrf_pkg::PATH_BYTES - 1);

    // Configuration registers.
    logic [15:0] header_limit_reg;
    logic [15:0] body_limit_reg;

    // Parser state.
    hrf_pkg::phase_t     phase_reg,      phase_next;
    logic [23:0]         recent_reg,     recent_next;
    logic [16:0]         hcount_reg,     hcount_next;
    logic [4:0]          mlen_reg,       mlen_next;
    logic [7:0]          plen_reg,       plen_next;
    logic [1:0]          lstat_reg,      lstat_next;
    logic [2:0]          mflags_reg,     mflags_next;
    hrf_pkg::len_state_t len_reg,        len_next;
    hrf_pkg::len_state_t len_upd;
    logic [15:0]         remain_reg,     remain_next;

    // Output register.
    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [2:0]  region_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [15:0] clen_reg;
    logic        breq_reg;

    // Per-byte result before registering.
    logic [2:0]  res_region;
    logic        res_last;
    logic [1:0]  res_status;
    logic [15:0] res_clen;
    logic        res_breq;

    logic        accept;
    logic        term;
    logic [7:0]  lb;
    logic [15:0] clip;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign lb        = hrf_pkg::to_lower(in_byte);

    hrf_len u_len (
        .byte_in (in_byte),
        .cur     (len_reg),
        .nxt     (len_upd)
    );

    assign clip = (len_reg.accum > 32'h0000_FFFF) ? 16'hFFFF : len_reg.accum[15:0];

    // The header ends on an LF that follows an LF, or CR LF CR.
    assign term = (in_byte == hrf_pkg::CH_LF) &&
                  (recent_reg[7:0] == hrf_pkg::CH_LF ||
                   (recent_reg[7:0] == hrf_pkg::CH_CR &&
                    recent_reg[15:8] == hrf_pkg::CH_LF &&
                    recent_reg[23:16] == hrf_pkg::CH_CR));

    always_comb
    begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        hcount_next = hcount_reg;
        mlen_next   = mlen_reg;
        plen_next   = plen_reg;
        lstat_next  = lstat_reg;
        mflags_next = mflags_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        res_region  = 3'(phase_reg);
        res_last    = 1'b0;
        res_status  = hrf_pkg::ST_BUSY;
        res_clen    = 16'd0;

        if (phase_reg == hrf_pkg::PH_BODY)
        begin
            res_clen = clip;
            if (remain_reg != 16'd0)
            begin
                remain_next = remain_reg - 16'd1;
            end
            if (remain_next == 16'd0)
            begin
                res_last   = 1'b1;
                res_status = hrf_pkg::ST_COMPLETE;
            end
        end
        else
        begin
            if (hcount_reg < 17'h10000)
            begin
                hcount_next = hcount_reg + 17'd1;
            end

            // Request line tracking.
            case (phase_reg)
                hrf_pkg::PH_METHOD:
                begin
                    if (in_byte == hrf_pkg::CH_SPACE)
                    begin
                        if (mlen_reg == 5'd0 && lstat_reg == hrf_pkg::ST_BUSY)
                        begin
                            lstat_next = hrf_pkg::ST_TOO_LARGE;
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            if (hrf_pkg::meth_len(2'(i)) != mlen_reg)
                            begin
                                mflags_next[i] = 1'b0;
                            end
                        end
                        phase_next = hrf_pkg::PH_PATH;
                    end
                    else if (in_byte == hrf_pkg::CH_LF)
                    begin
                        lstat_next  = hrf_pkg::ST_MALFORMED;
                        mflags_next = 3'b000;
                        phase_next  = hrf_pkg::PH_HEADER;
                    end
                    else if (mlen_reg >= METHOD_MAX)
                    begin
                        if (lstat_reg == hrf_pkg::ST_BUSY)
                        begin
                            lstat_next = hrf_pkg::ST_TOO_LARGE;
                        end
                        mflags_next = 3'b000;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (mlen_reg >= hrf_pkg::meth_len(2'(i)) ||
                                hrf_pkg::meth_char(2'(i), mlen_reg[2:0]) != lb)
                            begin
                                mflags_next[i] = 1'b0;
                            end
                        end
                        mlen_next = mlen_reg + 5'd1;
                    end
                end
                hrf_pkg::PH_PATH:
                begin
                    if (in_byte == hrf_pkg::CH_SPACE)
                    begin
                        if (plen_reg == 8'd0 && lstat_reg == hrf_pkg::ST_BUSY)
                        begin
                            lstat_next = hrf_pkg::ST_TOO_LARGE;
                        end
                        phase_next = hrf_pkg::PH_REST;
                    end
                    else if (in_byte == hrf_pkg::CH_LF)
                    begin
                        lstat_next = hrf_pkg::ST_MALFORMED;
                        phase_next = hrf_pkg::PH_HEADER;
                    end
                    else if (plen_reg >= PATH_MAX)
                    begin
                        if (lstat_reg == hrf_pkg::ST_BUSY)
                        begin
                            lstat_next = hrf_pkg::ST_TOO_LARGE;
                        end
                    end
                    else
                    begin
                        plen_next = plen_reg + 8'd1;
                    end
                end
                hrf_pkg::PH_REST:
                begin
                    if (in_byte == hrf_pkg::CH_LF)
                    begin
                        phase_next = hrf_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            len_next    = len_upd;
            recent_next = {recent_reg[15:0], in_byte};

            if (term)
            begin
                // Content-Length is unchanged by an LF, so the stored value stands.
                res_clen = clip;
                res_last = 1'b1;
                if (lstat_next != hrf_pkg::ST_BUSY)
                begin
                    res_status = lstat_next;
                end
                else if (len_next.invalid)
                begin
                    res_status = hrf_pkg::ST_MALFORMED;
                end
                else if (mflags_next != 3'b000 && !len_next.present)
                begin
                    res_status = hrf_pkg::ST_MALFORMED;
                end
                else if (len_next.accum > {16'd0, body_limit_reg})
                begin
                    res_status = hrf_pkg::ST_TOO_LARGE;
                end
                else if (len_next.accum == 32'd0)
                begin
                    res_status = hrf_pkg::ST_COMPLETE;
                end
                else
                begin
                    res_last    = 1'b0;
                    phase_next  = hrf_pkg::PH_BODY;
                    remain_next = len_next.accum[15:0];
                end
            end
            else if (hcount_next > {1'b0, header_limit_reg})
            begin
                res_last   = 1'b1;
                res_status = hrf_pkg::ST_TOO_LARGE;
            end
        end

        res_breq = (phase_next != hrf_pkg::PH_METHOD) && (mflags_next != 3'b000);
        out_valid_next = accept || in_stall;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_limit_reg <= 16'd1024;
            body_limit_reg   <= 16'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == hrf_pkg::REG_HEADER_LIMIT)
            begin
                header_limit_reg <= cfg_data;
            end
            else if (cfg_index == hrf_pkg::REG_BODY_LIMIT)
            begin
                body_limit_reg <= cfg_data;
            end
        end
    end

    // Parser state; a finished or rejected request returns it to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrf_pkg::PH_METHOD;
            recent_reg <= 24'd0;
            hcount_reg <= 17'd0;
            mlen_reg   <= 5'd0;
            plen_reg   <= 8'd0;
            lstat_reg  <= hrf_pkg::ST_BUSY;
            mflags_reg <= 3'b111;
            len_reg    <= '{lp: hrf_pkg::LP_NAME, name_pos: 5'd0, accum: 32'd0,
                            present: 1'b0, invalid: 1'b0, overflow: 1'b0};
            remain_reg <= 16'd0;
        end
        else if (accept)
        begin
            if (res_last)
            begin
                phase_reg  <= hrf_pkg::PH_METHOD;
                recent_reg <= 24'd0;
                hcount_reg <= 17'd0;
                mlen_reg   <= 5'd0;
                plen_reg   <= 8'd0;
                lstat_reg  <= hrf_pkg::ST_BUSY;
                mflags_reg <= 3'b111;
                len_reg    <= '{lp: hrf_pkg::LP_NAME, name_pos: 5'd0, accum: 32'd0,
                                present: 1'b0, invalid: 1'b0, overflow: 1'b0};
                remain_reg <= 16'd0;
            end
            else
            begin
                phase_reg  <= phase_next;
                recent_reg <= recent_next;
                hcount_reg <= hcount_next;
                mlen_reg   <= mlen_next;
                plen_reg   <= plen_next;
                lstat_reg  <= lstat_next;
                mflags_reg <= mflags_next;
                len_reg    <= len_next;
                remain_reg <= remain_next;
            end
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload; loaded only when a new request byte is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= in_byte;
            region_reg   <= res_region;
            last_reg     <= res_last;
            status_reg   <= res_status;
            clen_reg     <= res_clen;
            breq_reg     <= res_breq;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign byte_region     = region_reg;
    assign request_last    = last_reg;
    assign status          = status_reg;
    assign declared_length = clen_reg;
    assign body_required   = breq_reg;

endmodule

`default_nettype wire

>>> rtl/hrf_len.sv
// ----------------------------------------------------------------------------
// HTTP request framer Content-Length parser
// Next-state logic for matching the header name and accumulating its value.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_len (
    input  wire logic [7:0]         byte_in,
    input  hrf_pkg::len_state_t     cur,
    output hrf_pkg::len_state_t     nxt
);

    logic        ws;
    logic        dig;
    logic [35:0] prod;

    assign ws   = (byte_in == hrf_pkg::CH_SPACE) || (byte_in == hrf_pkg::CH_TAB);
    assign dig  = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    // accum * 10 + digit, wide enough to see a 32-bit overflow.
    assign prod = ({4'd0, cur.accum} << 3) + ({4'd0, cur.accum} << 1)
                + {32'd0, byte_in[3:0]};

    always_comb
    begin
        nxt = cur;
        if (cur.lp == hrf_pkg::LP_DONE)
        begin
            nxt = cur;
        end
        else if (byte_in == hrf_pkg::CH_LF)
        begin
            case (cur.lp)
                hrf_pkg::LP_LEAD:
                begin
                    nxt.invalid = 1'b1;
                    nxt.lp      = hrf_pkg::LP_DONE;
                end
                hrf_pkg::LP_DIGITS, hrf_pkg::LP_TRAIL:
                begin
                    nxt.present = 1'b1;
                    nxt.lp      = hrf_pkg::LP_DONE;
                end
                default:
                begin
                    nxt.lp       = hrf_pkg::LP_NAME;
                    nxt.name_pos = 5'd0;
                end
            endcase
        end
        else
        begin
            case (cur.lp)
                hrf_pkg::LP_NAME:
                begin
                    if (cur.name_pos < hrf_pkg::CL_NAME_LEN &&
                        hrf_pkg::to_lower(byte_in) == hrf_pkg::cl_char(cur.name_pos))
                    begin
                        nxt.name_pos = cur.name_pos + 5'd1;
                    end
                    else if (cur.name_pos == hrf_pkg::CL_NAME_LEN &&
                             byte_in == hrf_pkg::CH_COLON)
                    begin
                        nxt.lp = hrf_pkg::LP_LEAD;
                    end
                    else
                    begin
                        nxt.lp = hrf_pkg::LP_SKIP;
                    end
                end
                hrf_pkg::LP_LEAD:
                begin
                    if (dig)
                    begin
                        nxt.accum = {28'd0, byte_in[3:0]};
                        nxt.lp    = hrf_pkg::LP_DIGITS;
                    end
                    else if (!ws)
                    begin
                        nxt.invalid = 1'b1;
                        nxt.lp      = hrf_pkg::LP_DONE;
                    end
                end
                hrf_pkg::LP_DIGITS:
                begin
                    if (dig)
                    begin
                        if (prod > 36'hFFFF_FFFF)
                        begin
                            nxt.invalid  = 1'b1;
                            nxt.overflow = 1'b1;
                            nxt.lp       = hrf_pkg::LP_DONE;
                        end
                        else
                        begin
                            nxt.accum = prod[31:0];
                        end
                    end
                    else if (ws || byte_in == hrf_pkg::CH_CR)
                    begin
                        nxt.lp = hrf_pkg::LP_TRAIL;
                    end
                    else
                    begin
                        nxt.invalid = 1'b1;
                        nxt.lp      = hrf_pkg::LP_DONE;
                    end
                end
                hrf_pkg::LP_TRAIL:
                begin
                    if (!(ws || byte_in == hrf_pkg::CH_CR))
                    begin
                        nxt.invalid = 1'b1;
                        nxt.lp      = hrf_pkg::LP_DONE;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/hrf_checker.sv
// ----------------------------------------------------------------------------
// HTTP request framer checker
// Port-level checks of the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_framer_unit_assert.svh"

module hrf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic [2:0]  byte_region,
    input wire logic        request_last,
    input wire logic [1:0]  status,
    input wire logic [15:0] declared_length
);

    // A stalled result stays put.
    `HRF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte))
    // A final byte always carries a verdict.
    `HRF_ASSERT_SAME(a_last_status, clk, rst_n, out_valid && request_last,
                     status != hrf_pkg::ST_BUSY)
    // A verdict only appears on a final byte.
    `HRF_ASSERT_SAME(a_status_last, clk, rst_n, out_valid && status != hrf_pkg::ST_BUSY,
                     request_last)
    // Body bytes exist only for a nonzero declared length.
    `HRF_ASSERT_SAME(a_body_len, clk, rst_n, out_valid && byte_region == hrf_pkg::PH_BODY,
                     declared_length != 16'd0)

endmodule

bind http_request_framer_unit hrf_checker u_hrf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .byte_region     (byte_region),
    .request_last    (request_last),
    .status          (status),
    .declared_length (declared_length)
);

`default_nettype wire
